// ===== hdl/fpba_pkg.sv =====
// ----------------------------------------------------------------------------
// Fit-policy block allocator package
// Shared types, codes and default sizes for the allocator, its channels and its table rows.
// ----------------------------------------------------------------------------
`default_nettype none
package fpba_pkg;

  localparam int ADDR_W  = 16;
  localparam int COUNT_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 16;
  localparam int DEF_ARENA_BYTES  = 65536;

  typedef logic [1:0] op_t;
  localparam op_t OP_ALLOC = 2'd0;
  localparam op_t OP_FREE  = 2'd1;
  localparam op_t OP_COUNT = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_NO_FIT  = 2'd1;
  localparam status_t ST_FULL    = 2'd2;
  localparam status_t ST_BAD_OFS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ARENA_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 2'd1;

  // One row of the block table.
  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] bytes;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/fpba_in_if.sv =====
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
`default_nettype none
interface fpba_in_if;
  logic                       valid;
  logic                       ready;
  fpba_pkg::op_t              op;
  logic [fpba_pkg::ADDR_W-1:0] request_size;
  logic [fpba_pkg::ADDR_W-1:0] payload_offset;
  modport source (output valid, output op, output request_size, output payload_offset,
                  input ready);
  modport sink   (input valid, input op, input request_size, input payload_offset,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/fpba_out_if.sv =====
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
`default_nettype none
interface fpba_out_if;
  logic                         valid;
  logic                         ready;
  fpba_pkg::status_t            status;
  logic [fpba_pkg::ADDR_W-1:0]  granted_offset;
  logic [fpba_pkg::COUNT_W-1:0] small_free_count;
  modport source (output valid, output status, output granted_offset,
                  output small_free_count, input ready);
  modport sink   (input valid, input status, input granted_offset,
                  input small_free_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/fpba_ram.sv =====
// ----------------------------------------------------------------------------
// Generic table RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/fit_policy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Fit-policy block allocator
// Best/worst fit allocator over an address-ordered block table in a RAM.
// ----------------------------------------------------------------------------
// The block table lives in one RAM with a registered read port and is walked
// by a small sequencer, one entry per cycle. An allocate or a count query
// scans all n live entries; a split allocation then shifts the entries
// behind the chosen one down by one place (one entry per cycle) and writes
// the two halves. A free scans for the block and then runs one compaction
// pass over the table that merges adjacent free blocks. The request channel
// is ready only while the sequencer is idle, but a finished response waits
// in its own register, so the next request may be taken before the previous
// response is drained. After reset, and after each write of the arena size
// register, the table is rebuilt; no request is taken during the rebuild.
// ----------------------------------------------------------------------------
`default_nettype none
module fit_policy_block_allocator_unit #(
  parameter int MAX_BLOCKS   = fpba_pkg::DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = fpba_pkg::DEF_HEADER_BYTES,
  parameter int ARENA_BYTES  = fpba_pkg::DEF_ARENA_BYTES
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  fpba_in_if.sink                             in_chan,
  fpba_out_if.source                          out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fpba_pkg::ADDR_W-1:0]    cfg_wdata
);
  import fpba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [ADDR_W:0]   HDR17 = (ADDR_W+1)'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HDR   = ADDR_W'(HEADER_BYTES);
  localparam logic [31:0]       ARENA_CAP = 32'(ARENA_BYTES);
  localparam logic [CW-1:0]     CNT_MAX = CW'(MAX_BLOCKS);
  localparam logic [COUNT_W-1:0] QCNT_SAT = '1;

  // Sequencer states.
  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SPLIT  = 3'd4;
  localparam logic [2:0] S_SPLIT2 = 3'd5;
  localparam logic [2:0] S_MERGE  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [ADDR_W-1:0]  arena_r, arena_nxt;
  logic               mode_r, mode_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  op_t                op_r, op_nxt;
  logic [ADDR_W-1:0]  size_r, size_nxt;
  logic [ADDR_W-1:0]  offs_r, offs_nxt;
  logic [CW-1:0]      ri_r, ri_nxt;
  logic               d_vld_r, d_vld_nxt;
  logic [IW-1:0]      d_idx_r, d_idx_nxt;
  logic               found_r, found_nxt;
  logic [IW-1:0]      pick_r, pick_nxt;
  logic [ADDR_W-1:0]  best_r, best_nxt;
  logic [ADDR_W-1:0]  pstart_r, pstart_nxt;
  logic [COUNT_W-1:0] qcnt_r, qcnt_nxt;
  entry_t             cur_r, cur_nxt;
  logic               cur_vld_r, cur_vld_nxt;
  logic [IW-1:0]      w_r, w_nxt;
  status_t            res_st_r, res_st_nxt;
  logic [ADDR_W-1:0]  res_gr_r, res_gr_nxt;
  logic [COUNT_W-1:0] res_ct_r, res_ct_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_st_r, out_st_nxt;
  logic [ADDR_W-1:0]  out_gr_r, out_gr_nxt;
  logic [COUNT_W-1:0] out_ct_r, out_ct_nxt;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  entry_t             ram_rdata;
  logic [ADDR_W-1:0]  arena_eff;
  entry_t             e;
  logic               fits;
  logic [ADDR_W-1:0]  left;
  logic               scan_end;

  fpba_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ri_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_chan.ready             = (state_r == S_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_st_r;
  assign out_chan.granted_offset   = out_gr_r;
  assign out_chan.small_free_count = out_ct_r;

  // The arena is capped by the largest arena the block is built for.
  assign arena_eff = (32'(arena_r) > ARENA_CAP) ? ARENA_CAP[ADDR_W-1:0] : arena_r;

  // Read data for the entry whose address was issued in the previous cycle.
  // During a free's compaction pass the block being freed counts as free.
  always_comb begin
    e = ram_rdata;
    if (state_r == S_MERGE && d_idx_r == pick_r) begin
      e.free = 1'b1;
    end
  end

  assign fits = e.free && (e.bytes == size_r ||
                           {1'b0, e.bytes} >= ({1'b0, size_r} + HDR17));
  assign left = e.bytes - size_r;
  assign scan_end = (ri_r == cnt_r) && !d_vld_r;

  always_comb begin
    state_nxt   = state_r;
    arena_nxt   = arena_r;
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    op_nxt      = op_r;
    size_nxt    = size_r;
    offs_nxt    = offs_r;
    ri_nxt      = ri_r;
    d_vld_nxt   = 1'b0;
    d_idx_nxt   = ri_r[IW-1:0];
    found_nxt   = found_r;
    pick_nxt    = pick_r;
    best_nxt    = best_r;
    pstart_nxt  = pstart_r;
    qcnt_nxt    = qcnt_r;
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    w_nxt       = w_r;
    res_st_nxt  = res_st_r;
    res_gr_nxt  = res_gr_r;
    res_ct_nxt  = res_ct_r;
    out_st_nxt  = out_st_r;
    out_gr_nxt  = out_gr_r;
    out_ct_nxt  = out_ct_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;

    case (state_r)
      S_INIT: begin
        // Rebuild the table as one free block spanning the arena.
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.free  = 1'b1;
        ram_wdata.start = '0;
        ram_wdata.bytes = (arena_eff >= HDR) ? arena_eff - HDR : '0;
        cnt_nxt         = CW'(1);
        state_nxt       = S_IDLE;
      end

      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt     = in_chan.op;
          size_nxt   = in_chan.request_size;
          offs_nxt   = in_chan.payload_offset;
          ri_nxt     = '0;
          found_nxt  = 1'b0;
          qcnt_nxt   = '0;
          res_st_nxt = ST_OK;
          res_gr_nxt = '0;
          res_ct_nxt = '0;
          case (in_chan.op)
            OP_ALLOC, OP_FREE, OP_COUNT: state_nxt = S_SCAN;
            default:                     state_nxt = S_DONE;
          endcase
        end
      end

      S_SCAN: begin
        if (ri_r < cnt_r) begin
          d_vld_nxt = 1'b1;
          ri_nxt    = ri_r + CW'(1);
        end
        if (d_vld_r) begin
          case (op_r)
            OP_ALLOC: begin
              if (fits && (!found_r || (mode_r ? left >= best_r : left <= best_r))) begin
                found_nxt  = 1'b1;
                pick_nxt   = d_idx_r;
                best_nxt   = left;
                pstart_nxt = e.start;
              end
            end
            OP_FREE: begin
              if (!found_r && !e.free &&
                  ({1'b0, e.start} + HDR17) == {1'b0, offs_r}) begin
                found_nxt = 1'b1;
                pick_nxt  = d_idx_r;
              end
            end
            default: begin
              if (e.free && e.bytes < size_r && qcnt_r != QCNT_SAT) begin
                qcnt_nxt = qcnt_r + COUNT_W'(1);
              end
            end
          endcase
        end
        if (scan_end) begin
          case (op_r)
            OP_ALLOC: begin
              if (!found_r) begin
                res_st_nxt = ST_NO_FIT;
                state_nxt  = S_DONE;
              end else if (best_r == '0) begin
                // Exact fit: just mark the block taken.
                ram_we          = 1'b1;
                ram_waddr       = pick_r;
                ram_wdata.free  = 1'b0;
                ram_wdata.start = pstart_r;
                ram_wdata.bytes = size_r;
                res_gr_nxt      = pstart_r + HDR;
                state_nxt       = S_DONE;
              end else if (cnt_r >= CNT_MAX) begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                ri_nxt    = cnt_r - CW'(1);
                state_nxt = S_SHIFT;
              end
            end
            OP_FREE: begin
              if (!found_r) begin
                res_st_nxt = ST_BAD_OFS;
                state_nxt  = S_DONE;
              end else begin
                ri_nxt      = '0;
                cur_vld_nxt = 1'b0;
                w_nxt       = '0;
                state_nxt   = S_MERGE;
              end
            end
            default: begin
              res_ct_nxt = qcnt_r;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // Move entries behind the split block one place down, last first.
        if (ri_r > CW'(pick_r)) begin
          d_vld_nxt = 1'b1;
          ri_nxt    = ri_r - CW'(1);
        end
        if (d_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = d_idx_r + IW'(1);
          ram_wdata = ram_rdata;
        end
        if (!d_vld_r && !(ri_r > CW'(pick_r))) begin
          state_nxt = S_SPLIT;
        end
      end

      S_SPLIT: begin
        ram_we          = 1'b1;
        ram_waddr       = pick_r + IW'(1);
        ram_wdata.free  = 1'b1;
        ram_wdata.start = pstart_r + HDR + size_r;
        ram_wdata.bytes = best_r - HDR;
        state_nxt       = S_SPLIT2;
      end

      S_SPLIT2: begin
        ram_we          = 1'b1;
        ram_waddr       = pick_r;
        ram_wdata.free  = 1'b0;
        ram_wdata.start = pstart_r;
        ram_wdata.bytes = size_r;
        cnt_nxt         = cnt_r + CW'(1);
        res_gr_nxt      = pstart_r + HDR;
        state_nxt       = S_DONE;
      end

      S_MERGE: begin
        // Stream the table through a one-entry holder, folding each free
        // entry into a free holder and writing back everything else.
        if (ri_r < cnt_r) begin
          d_vld_nxt = 1'b1;
          ri_nxt    = ri_r + CW'(1);
        end
        if (d_vld_r) begin
          if (!cur_vld_r) begin
            cur_nxt     = e;
            cur_vld_nxt = 1'b1;
          end else if (cur_r.free && e.free) begin
            cur_nxt.bytes = cur_r.bytes + e.bytes + HDR;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = w_r;
            ram_wdata = cur_r;
            w_nxt     = w_r + IW'(1);
            cur_nxt   = e;
          end
        end
        if (scan_end) begin
          ram_we    = 1'b1;
          ram_waddr = w_r;
          ram_wdata = cur_r;
          cnt_nxt   = CW'(w_r) + CW'(1);
          state_nxt = S_DONE;
        end
      end

      default: begin
        // Hand the response to the output register once it is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_gr_nxt    = res_gr_r;
          out_ct_nxt    = res_ct_r;
          state_nxt     = S_IDLE;
        end
      end
    endcase

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
    if (cfg_we) begin
      if (cfg_index == REG_ARENA_SIZE) begin
        arena_nxt = cfg_wdata;
        state_nxt = S_INIT;
      end else if (cfg_index == REG_FIT_MODE) begin
        mode_nxt = cfg_wdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      arena_r     <= '1;
      mode_r      <= 1'b0;
      cnt_r       <= CW'(1);
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      cur_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arena_r     <= arena_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      d_vld_r     <= d_vld_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      cur_vld_r   <= cur_vld_nxt;
    end
    op_r     <= op_nxt;
    size_r   <= size_nxt;
    offs_r   <= offs_nxt;
    ri_r     <= ri_nxt;
    d_idx_r  <= d_idx_nxt;
    pick_r   <= pick_nxt;
    best_r   <= best_nxt;
    pstart_r <= pstart_nxt;
    qcnt_r   <= qcnt_nxt;
    cur_r    <= cur_nxt;
    w_r      <= w_nxt;
    res_st_r <= res_st_nxt;
    res_gr_r <= res_gr_nxt;
    res_ct_r <= res_ct_nxt;
    out_st_r <= out_st_nxt;
    out_gr_r <= out_gr_nxt;
    out_ct_r <= out_ct_nxt;
  end
endmodule
`default_nettype wire

// ===== dv/fpba_arena_scoreboard.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Allocator response scoreboard
// Predicts each response from a private copy of the block table and checks
// the responses in order.
// ----------------------------------------------------------------------------
class fpba_arena_scoreboard;
  localparam int N_BLK = fpba_pkg::DEF_MAX_BLOCKS;
  localparam int HDR   = fpba_pkg::DEF_HEADER_BYTES;

  typedef struct {
    fpba_pkg::status_t status;
    logic [15:0]       granted;
    logic [6:0]        count;
  } resp_t;

  int unsigned blk_start [N_BLK];
  int unsigned blk_bytes [N_BLK];
  bit          blk_free  [N_BLK];
  int unsigned n_live;
  int unsigned arena_bytes;
  bit          worst_fit;
  resp_t       pending[$];
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned n_split, n_exact, n_nofit, n_full, n_bad, n_merge;

  function new();
    arena_bytes = 65535;
    worst_fit   = 1'b0;
    rebuild_table();
  endfunction

  function void rebuild_table();
    for (int i = 0; i < N_BLK; i++) begin
      blk_start[i] = 0;
      blk_bytes[i] = 0;
      blk_free[i]  = 1'b0;
    end
    blk_bytes[0] = (arena_bytes >= HDR) ? arena_bytes - HDR : 0;
    blk_free[0]  = 1'b1;
    n_live       = 1;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] value);
    if (idx == fpba_pkg::REG_ARENA_SIZE) begin
      arena_bytes = 32'(value);
      rebuild_table();
    end else if (idx == fpba_pkg::REG_FIT_MODE) begin
      worst_fit = value[0];
    end
  endfunction

  function void merge_neighbors();
    int unsigned i;
    i = 0;
    while (i + 1 < n_live) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_bytes[i] = blk_bytes[i] + blk_bytes[i+1] + HDR;
        for (int k = i + 1; k + 1 < n_live; k++) begin
          blk_start[k] = blk_start[k+1];
          blk_bytes[k] = blk_bytes[k+1];
          blk_free[k]  = blk_free[k+1];
        end
        n_live--;
        n_merge++;
      end else begin
        i++;
      end
    end
  endfunction

  // Works out the response of one accepted request and queues it.
  function void note_request(fpba_pkg::op_t op, logic [15:0] size, logic [15:0] ofs);
    resp_t       r;
    bit          found;
    int unsigned pick, best_left, left;
    r.status  = fpba_pkg::ST_OK;
    r.granted = '0;
    r.count   = '0;
    found     = 1'b0;
    pick      = 0;
    best_left = 0;
    if (op == fpba_pkg::OP_ALLOC) begin
      for (int i = 0; i < n_live; i++) begin
        if (blk_free[i] && (blk_bytes[i] == size || blk_bytes[i] >= size + HDR)) begin
          left = blk_bytes[i] - size;
          if (!found || (!worst_fit ? left <= best_left : left >= best_left)) begin
            found     = 1'b1;
            pick      = i;
            best_left = left;
          end
        end
      end
      if (!found) begin
        r.status = fpba_pkg::ST_NO_FIT;
        n_nofit++;
      end else if (best_left == 0) begin
        blk_free[pick] = 1'b0;
        r.granted      = 16'(blk_start[pick] + HDR);
        n_exact++;
      end else if (n_live >= N_BLK) begin
        r.status = fpba_pkg::ST_FULL;
        n_full++;
      end else begin
        for (int k = n_live; k > pick + 1; k--) begin
          blk_start[k] = blk_start[k-1];
          blk_bytes[k] = blk_bytes[k-1];
          blk_free[k]  = blk_free[k-1];
        end
        blk_start[pick+1] = blk_start[pick] + HDR + size;
        blk_bytes[pick+1] = best_left - HDR;
        blk_free[pick+1]  = 1'b1;
        n_live++;
        blk_bytes[pick] = size;
        blk_free[pick]  = 1'b0;
        r.granted       = 16'(blk_start[pick] + HDR);
        n_split++;
      end
    end else if (op == fpba_pkg::OP_FREE) begin
      for (int i = 0; i < n_live; i++) begin
        if (!found && !blk_free[i] && blk_start[i] + HDR == ofs) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (!found) begin
        r.status = fpba_pkg::ST_BAD_OFS;
        n_bad++;
      end else begin
        blk_free[pick] = 1'b1;
        merge_neighbors();
      end
    end else if (op == fpba_pkg::OP_COUNT) begin
      for (int i = 0; i < n_live; i++) begin
        if (blk_free[i] && blk_bytes[i] < size && r.count < 127) r.count++;
      end
    end
    pending.push_back(r);
  endfunction

  // Picks a live allocated offset, or returns 0 when none exists.
  function logic [15:0] some_used_offset();
    int unsigned idx [$];
    for (int i = 0; i < n_live; i++) if (!blk_free[i]) idx.push_back(i);
    if (idx.size() == 0) return 16'd0;
    return 16'(blk_start[idx[$urandom_range(idx.size() - 1)]] + HDR);
  endfunction

  function void check_response(fpba_pkg::status_t st, logic [15:0] g, logic [6:0] c);
    resp_t e;
    n_checked++;
    if (pending.size() == 0) begin
      report("response with none expected");
      return;
    end
    e = pending.pop_front();
    if (st !== e.status)
      report($sformatf("status %0d, expected %0d", st, e.status));
    if (g !== e.granted)
      report($sformatf("granted_offset %0d, expected %0d", g, e.granted));
    if (c !== e.count)
      report($sformatf("small_free_count %0d, expected %0d", c, e.count));
  endfunction

  function void report(string msg);
    n_errors++;
    if (n_errors <= 30) $display("mismatch at response %0d: %s", n_checked, msg);
  endfunction
endclass

// ===== dv/fpba_chan_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench channel note
// The channels reuse the request and response interfaces of the design.
// ----------------------------------------------------------------------------
package fpba_tb_pkg;
  localparam int LONG_HOLD_CYCLES = 3000;
endpackage

// ===== dv/fit_policy_block_allocator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fit-policy block allocator testbench
// Drives allocate, free, count and unused-op requests with random gaps on
// both sides, predicts each response from a private block table and checks
// every word.
module fit_policy_block_allocator_unit_test;
  import fpba_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  fpba_in_if  req_chan ();
  fpba_out_if rsp_chan ();

  fit_policy_block_allocator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_chan.sink),
    .out_chan (rsp_chan.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  fpba_arena_scoreboard arena = new();

  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;   // when nonzero the receiver stays stalled
  int unsigned n_sent = 0;

  always #5 clk = ~clk;

  initial begin
    req_chan.valid          = 1'b0;
    req_chan.op             = OP_ALLOC;
    req_chan.request_size   = '0;
    req_chan.payload_offset = '0;
    rsp_chan.ready          = 1'b0;
  end

  // Most gaps are short; now and then one runs long.
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(3);
    return $urandom_range(150, 20);
  endfunction

  // Receiver: random stalls, now and then a longer one, plus one long hold.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_cycles != 0) begin
        rsp_chan.ready <= 1'b0;
        hold_cycles    <= hold_cycles - 1;
      end else begin
        rsp_chan.ready <= ($urandom_range(9) < 7);
        if ($urandom_range(199) == 0) hold_cycles <= $urandom_range(150, 20);
      end
      if (rsp_chan.valid && rsp_chan.ready)
        arena.check_response(rsp_chan.status, rsp_chan.granted_offset,
                             rsp_chan.small_free_count);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offers one request word and waits for it to be taken; the model is
  // updated at the accepting edge. Valid drops only when a gap follows.
  task automatic send_request(op_t op, logic [15:0] size, logic [15:0] ofs);
    int unsigned g;
    g = gap_len();
    if (g != 0) req_chan.valid <= 1'b0;
    repeat (g) @(posedge clk);
    req_chan.valid          <= 1'b1;
    req_chan.op             <= op;
    req_chan.request_size   <= size;
    req_chan.payload_offset <= ofs;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    arena.note_request(op, size, ofs);
    n_sent++;
  endtask

  // Waits until every response has been checked, then lets the sequencer
  // settle before any register write.
  task automatic drain();
    req_chan.valid <= 1'b0;
    while (arena.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    arena.write_reg(idx, value);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Mostly small sizes so the table fills and splits often.
  function automatic logic [15:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 60) return 16'($urandom_range(64));
    if (p < 85) return 16'($urandom_range(1024));
    if (p < 95) return 16'($urandom_range(65535));
    return 16'hFFFF;
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 45) send_request(OP_ALLOC, rand_size(), 16'($urandom));
      else if (p < 80) send_request(OP_FREE, 16'($urandom), arena.some_used_offset());
      else if (p < 86) send_request(OP_FREE, 16'($urandom), 16'($urandom));
      else if (p < 96) send_request(OP_COUNT, rand_size(), 16'($urandom));
      else send_request(2'd3, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // Directed: exact fit of the whole arena, the largest fields, bad and
    // double frees, the unused op, and counting.
    send_request(OP_COUNT, 16'hFFFF, 16'h0);
    send_request(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send_request(OP_ALLOC, 16'd65519, 16'h0);
    send_request(OP_FREE, 16'h0, 16'd16);
    send_request(OP_FREE, 16'h0, 16'd16);
    send_request(OP_ALLOC, 16'd0, 16'h0);
    send_request(OP_ALLOC, 16'd100, 16'h0);
    send_request(OP_ALLOC, 16'd10, 16'h0);
    send_request(OP_FREE, 16'hFFFF, 16'hFFFF);
    send_request(2'd3, 16'hFFFF, 16'hFFFF);
    send_request(OP_FREE, 16'h0, 16'd16);
    send_request(OP_COUNT, 16'd0, 16'h0);
    send_request(OP_COUNT, 16'd200, 16'h0);
    drain();

    // Tiny arena below the header size, then the smallest legal arena.
    write_reg(REG_ARENA_SIZE, 16'd5);
    send_request(OP_ALLOC, 16'd0, 16'h0);
    send_request(OP_ALLOC, 16'd0, 16'h0);
    send_request(OP_COUNT, 16'd1, 16'h0);
    drain();
    write_reg(REG_ARENA_SIZE, 16'd16);
    write_reg(2'd3, 16'hFFFF);
    send_request(OP_COUNT, 16'd1, 16'h0);
    drain();

    // Fill the table with many small blocks to reach table full.
    write_reg(REG_ARENA_SIZE, 16'd4000);
    for (int i = 0; i < 70; i++) send_request(OP_ALLOC, 16'd8, 16'h0);
    drain();

    // Long receiver hold while the sender keeps offering words.
    hold_cycles = fpba_tb_pkg::LONG_HOLD_CYCLES;
    random_phase(60);
    drain();

    write_reg(REG_FIT_MODE, 16'd1);
    write_reg(REG_ARENA_SIZE, 16'hFFFF);
    random_phase(250);
    drain();

    write_reg(REG_FIT_MODE, 16'd0);
    write_reg(REG_ARENA_SIZE, 16'd2048);
    random_phase(250);
    drain();

    write_reg(REG_FIT_MODE, 16'd1);
    write_reg(REG_ARENA_SIZE, 16'd600);
    random_phase(150);
    drain();

    $display("%0d requests, %0d responses: %0d split and %0d exact grants, %0d no-fit,",
             n_sent, arena.n_checked, arena.n_split, arena.n_exact, arena.n_nofit);
    $display("%0d table-full, %0d bad frees, %0d merges, over both fit modes",
             arena.n_full, arena.n_bad, arena.n_merge);
    if (arena.n_errors == 0 && arena.pending.size() == 0 &&
        arena.n_checked == n_sent) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
